// ----- hdl/refa_pkg.sv -----
// types and constants shared by the rotary encoder field adjust block
`default_nettype none

package refa_pkg;

  typedef enum logic [2:0] {
    FUNC_MENU    = 3'd0,
    FUNC_HOUR    = 3'd1,
    FUNC_MINUTE  = 3'd2,
    FUNC_SECOND  = 3'd3,
    FUNC_WEEKDAY = 3'd4,
    FUNC_DATE    = 3'd5,
    FUNC_MONTH   = 3'd6,
    FUNC_YEAR    = 3'd7
  } field_sel_t;

  localparam int unsigned ValueW = 7;

  localparam logic [ValueW-1:0] MENU_MAX    = 7'd3;
  localparam logic [ValueW-1:0] HOUR_MAX    = 7'd23;
  localparam logic [ValueW-1:0] MINSEC_MAX  = 7'd59;
  localparam logic [ValueW-1:0] WEEKDAY_MAX = 7'd7;
  localparam logic [ValueW-1:0] DATE_MAX    = 7'd31;
  localparam logic [ValueW-1:0] MONTH_MAX   = 7'd12;
  localparam logic [ValueW-1:0] YEAR_MAX    = 7'd99;
  localparam logic [ValueW-1:0] FIELD_ZERO  = 7'd0;
  localparam logic [ValueW-1:0] FIELD_ONE   = 7'd1;
  localparam logic [ValueW-1:0] YEAR_RESET  = 7'd23;

  typedef struct packed {
    logic       clk_level;
    logic       dt_level;
    field_sel_t func;
  } item_t;

  typedef struct packed {
    logic [ValueW-1:0] field_value;
    logic              moved;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/refa_if.sv -----
// valid/ready channels for encoder poll words and result words
`default_nettype none

interface refa_item_if import refa_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       clk_level;
  logic       dt_level;
  logic [2:0] func;

  modport source (output valid, output clk_level, output dt_level, output func,
                  input ready);
  modport sink   (input valid, input clk_level, input dt_level, input func,
                  output ready);
endinterface

interface refa_result_if import refa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] field_value;
  logic              moved;

  modport source (output valid, output field_value, output moved, input ready);
  modport sink   (input valid, input field_value, input moved, output ready);
endinterface

`default_nettype wire

// ----- hdl/refa_field_bank.sv -----
// field registers with the wrap and saturate step logic
`default_nettype none

module refa_field_bank import refa_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    step,
  input  wire item_t   item,
  output result_t      res
);

  logic              last_clock;
  logic              primed;
  logic [1:0]        menu_index;
  logic [4:0]        hour;
  logic [5:0]        minutes;
  logic [5:0]        seconds;
  logic [2:0]        weekday;
  logic [4:0]        day_of_month;
  logic [3:0]        month;
  logic [6:0]        year;

  logic [ValueW-1:0] old_value;
  logic [ValueW-1:0] lo;
  logic [ValueW-1:0] hi;
  logic              sat;
  logic              up;
  logic              clock_change;
  logic [ValueW-1:0] stepped;
  logic [ValueW-1:0] new_value;

  always_comb begin
    old_value = FIELD_ZERO;
    lo        = FIELD_ZERO;
    hi        = MENU_MAX;
    sat       = 1'b0;
    unique case (item.func)
      FUNC_MENU: begin
        old_value = {5'd0, menu_index};
        hi        = MENU_MAX;
      end
      FUNC_HOUR: begin
        old_value = {2'd0, hour};
        hi        = HOUR_MAX;
      end
      FUNC_MINUTE: begin
        old_value = {1'd0, minutes};
        hi        = MINSEC_MAX;
      end
      FUNC_SECOND: begin
        old_value = {1'd0, seconds};
        hi        = MINSEC_MAX;
      end
      FUNC_WEEKDAY: begin
        old_value = {4'd0, weekday};
        lo        = FIELD_ONE;
        hi        = WEEKDAY_MAX;
      end
      FUNC_DATE: begin
        old_value = {2'd0, day_of_month};
        lo        = FIELD_ONE;
        hi        = DATE_MAX;
      end
      FUNC_MONTH: begin
        old_value = {3'd0, month};
        lo        = FIELD_ONE;
        hi        = MONTH_MAX;
      end
      FUNC_YEAR: begin
        old_value = year;
        hi        = YEAR_MAX;
        sat       = 1'b1;
      end
      default: begin
        old_value = FIELD_ZERO;
      end
    endcase
  end

  assign up           = item.dt_level != item.clk_level;
  assign clock_change = primed && (item.clk_level != last_clock);

  always_comb begin
    if (up) begin
      stepped = (old_value >= hi) ? (sat ? hi : lo) : old_value + FIELD_ONE;
    end else begin
      stepped = (old_value <= lo) ? (sat ? lo : hi) : old_value - FIELD_ONE;
    end
    new_value       = clock_change ? stepped : old_value;
    res.field_value = new_value;
    res.moved       = clock_change && (stepped != old_value);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_clock   <= 1'b0;
      primed       <= 1'b0;
      menu_index   <= 2'd0;
      hour         <= 5'd0;
      minutes      <= 6'd0;
      seconds      <= 6'd0;
      weekday      <= 3'd1;
      day_of_month <= 5'd1;
      month        <= 4'd1;
      year         <= YEAR_RESET;
    end else if (step) begin
      last_clock <= item.clk_level;
      primed     <= 1'b1;
      if (clock_change) begin
        unique case (item.func)
          FUNC_MENU:    menu_index   <= stepped[1:0];
          FUNC_HOUR:    hour         <= stepped[4:0];
          FUNC_MINUTE:  minutes      <= stepped[5:0];
          FUNC_SECOND:  seconds      <= stepped[5:0];
          FUNC_WEEKDAY: weekday      <= stepped[2:0];
          FUNC_DATE:    day_of_month <= stepped[4:0];
          FUNC_MONTH:   month        <= stepped[3:0];
          FUNC_YEAR:    year         <= stepped;
          default:      year         <= year;
        endcase
      end
    end
  end

  a_first_poll_still: assert property (@(posedge clk) disable iff (rst)
    !primed |-> !res.moved)
    else $error("field moved on the priming poll");

  a_ranges: assert property (@(posedge clk) disable iff (rst)
    year <= YEAR_MAX && {2'd0, hour} <= HOUR_MAX && {1'd0, minutes} <= MINSEC_MAX
    && {1'd0, seconds} <= MINSEC_MAX && weekday != 3'd0)
    else $error("field left its range");

  a_calendar: assert property (@(posedge clk) disable iff (rst)
    day_of_month != 5'd0 && month != 4'd0 && {3'd0, month} <= MONTH_MAX)
    else $error("date or month left its range");

  a_clock_tracked: assert property (@(posedge clk) disable iff (rst)
    step |=> primed && last_clock == $past(item.clk_level))
    else $error("stored clock level not updated");

endmodule

`default_nettype wire

// ----- hdl/rotary_encoder_field_adjust.sv -----
// top level: poll register, field bank and result register
// a poll word's result passes through the poll register and then the result register
// throughput: one poll word per cycle while results are taken, set by the single field update stage
// the result register lets a new poll in while a result waits to be taken
// reset (rst, synchronous): clears both stages, primes nothing, fields to
// their initial values; the first poll afterwards only stores the clock level
`default_nettype none

module rotary_encoder_field_adjust import refa_pkg::*; (
  input wire logic     clk,
  input wire logic     rst,
  refa_item_if.sink    item,
  refa_result_if.source result
);

  logic    s1_valid;
  item_t   s1_item;
  logic    out_valid;
  result_t out_result;
  result_t bank_res;
  logic    advance;

  assign advance    = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_item.clk_level <= item.clk_level;
      s1_item.dt_level  <= item.dt_level;
      s1_item.func      <= field_sel_t'(item.func);
    end
  end

  refa_field_bank u_bank (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (s1_item),
    .res  (bank_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= bank_res;
    end
  end

  assign result.valid       = out_valid;
  assign result.field_value = out_result.field_value;
  assign result.moved       = out_result.moved;

endmodule

`default_nettype wire

// ----- dv/rotary_encoder_field_adjust_tb.sv -----
// testbench for the rotary encoder field adjust block: table and random polls
`timescale 1ns / 100ps

module rotary_encoder_field_adjust_tb;
  import refa_pkg::*;

  localparam int PollTarget  = 1950;
  localparam int CycleLimit  = 200000;
  localparam int IdlePercent = 9;
  localparam int CalmFrom    = 800;
  localparam int CalmTo      = 1100;
  localparam int HoldAt      = 400;
  localparam int HoldCycles  = 60;
  localparam int TableRows   = 21;

  typedef struct packed {
    logic              clk_level;
    logic              dt_level;
    field_sel_t        func;
    logic              typed;
    logic [ValueW-1:0] value;
    logic              moved;
  } poll_row_t;

  logic clk = 1'b0;
  logic rst;

  refa_item_if   item_ch ();
  refa_result_if result_ch ();

  rotary_encoder_field_adjust DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // field bank as the block should hold it
  logic [ValueW-1:0] fields [8];
  logic              primed;
  logic              last_clock;

  result_t   due_results [$];
  poll_row_t poll_table [TableRows];
  int        polls_sent    = 0;
  int        results_taken = 0;
  int        mismatches    = 0;
  int        cycles        = 0;

  function automatic result_t turn_field(item_t p);
    result_t           r;
    logic [ValueW-1:0] old;
    logic [ValueW-1:0] nxt;
    logic [ValueW-1:0] lo;
    logic [ValueW-1:0] hi;
    logic              up;
    lo = FIELD_ZERO;
    case (p.func)
      FUNC_MENU:                hi = MENU_MAX;
      FUNC_HOUR:                hi = HOUR_MAX;
      FUNC_MINUTE, FUNC_SECOND: hi = MINSEC_MAX;
      FUNC_WEEKDAY: begin
        hi = WEEKDAY_MAX;
        lo = FIELD_ONE;
      end
      FUNC_DATE: begin
        hi = DATE_MAX;
        lo = FIELD_ONE;
      end
      FUNC_MONTH: begin
        hi = MONTH_MAX;
        lo = FIELD_ONE;
      end
      default:                  hi = YEAR_MAX;
    endcase
    old = fields[p.func];
    nxt = old;
    if (primed && p.clk_level != last_clock) begin
      up = p.dt_level != p.clk_level;
      // the year stops at its limits, every other field wraps
      if (up) begin
        nxt = (old >= hi) ? ((p.func == FUNC_YEAR) ? hi : lo) : old + 1'b1;
      end else begin
        nxt = (old <= lo) ? ((p.func == FUNC_YEAR) ? lo : hi) : old - 1'b1;
      end
      fields[p.func] = nxt;
    end
    primed = 1'b1;
    last_clock = p.clk_level;
    r.field_value = nxt;
    r.moved = (nxt != old);
    return r;
  endfunction

  task automatic note_mismatch(string what, int want, int got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch on %s at word %0d: expected %0d, got %0d",
               what, results_taken, want, got);
    end
  endtask

  task automatic send_poll(item_t p, logic typed, result_t given);
    result_t r;
    while (!(polls_sent >= CalmFrom && polls_sent < CalmTo) &&
           $urandom_range(99) < IdlePercent) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.clk_level <= p.clk_level;
    item_ch.dt_level  <= p.dt_level;
    item_ch.func      <= p.func;
    do @(posedge clk); while (!item_ch.ready);
    r = turn_field(p);
    due_results.push_back(typed ? given : r);
    polls_sent++;
  endtask

  // result side: checks and back-pressure
  initial begin
    result_t want;
    int      hold_left;
    bit      held;
    hold_left = 0;
    held = 1'b0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        if (due_results.size() == 0) begin
          note_mismatch("unexpected word", -1, result_ch.field_value);
        end else begin
          want = due_results.pop_front();
          if (result_ch.field_value !== want.field_value) begin
            note_mismatch("field_value", want.field_value, result_ch.field_value);
          end
          if (result_ch.moved !== want.moved) begin
            note_mismatch("moved", want.moved, result_ch.moved);
          end
        end
        results_taken++;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (!held && results_taken >= HoldAt) begin
        held = 1'b1;
        hold_left = HoldCycles;
        result_ch.ready <= 1'b0;
      end else if (results_taken >= CalmFrom && results_taken < CalmTo) begin
        result_ch.ready <= 1'b1;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= IdlePercent);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    item_t      p;
    field_sel_t sel;
    logic       up;
    int         steps;
    rst               <= 1'b1;
    item_ch.valid     <= 1'b0;
    item_ch.clk_level <= 1'b0;
    item_ch.dt_level  <= 1'b0;
    item_ch.func      <= FUNC_MENU;

    fields[FUNC_MENU]    = FIELD_ZERO;
    fields[FUNC_HOUR]    = FIELD_ZERO;
    fields[FUNC_MINUTE]  = FIELD_ZERO;
    fields[FUNC_SECOND]  = FIELD_ZERO;
    fields[FUNC_WEEKDAY] = FIELD_ONE;
    fields[FUNC_DATE]    = FIELD_ONE;
    fields[FUNC_MONTH]   = FIELD_ONE;
    fields[FUNC_YEAR]    = YEAR_RESET;
    primed     = 1'b0;
    last_clock = 1'b0;

    // first poll only primes, then each field but the year across both ends of its range
    poll_table = '{
      '{1'b1, 1'b0, FUNC_YEAR,    1'b1, YEAR_RESET,  1'b0},
      '{1'b1, 1'b1, FUNC_MENU,    1'b1, FIELD_ZERO,  1'b0},
      '{1'b0, 1'b0, FUNC_MENU,    1'b1, MENU_MAX,    1'b1},
      '{1'b1, 1'b0, FUNC_MENU,    1'b1, FIELD_ZERO,  1'b1},
      '{1'b0, 1'b0, FUNC_HOUR,    1'b1, HOUR_MAX,    1'b1},
      '{1'b1, 1'b0, FUNC_HOUR,    1'b1, FIELD_ZERO,  1'b1},
      '{1'b0, 1'b0, FUNC_MINUTE,  1'b1, MINSEC_MAX,  1'b1},
      '{1'b1, 1'b0, FUNC_MINUTE,  1'b1, FIELD_ZERO,  1'b1},
      '{1'b0, 1'b0, FUNC_SECOND,  1'b1, MINSEC_MAX,  1'b1},
      '{1'b1, 1'b1, FUNC_SECOND,  1'b0, FIELD_ZERO,  1'b0},
      '{1'b0, 1'b1, FUNC_WEEKDAY, 1'b0, FIELD_ZERO,  1'b0},
      '{1'b1, 1'b1, FUNC_WEEKDAY, 1'b0, FIELD_ZERO,  1'b0},
      '{1'b0, 1'b0, FUNC_WEEKDAY, 1'b1, WEEKDAY_MAX, 1'b1},
      '{1'b1, 1'b0, FUNC_WEEKDAY, 1'b1, FIELD_ONE,   1'b1},
      '{1'b0, 1'b0, FUNC_DATE,    1'b1, DATE_MAX,    1'b1},
      '{1'b1, 1'b0, FUNC_DATE,    1'b1, FIELD_ONE,   1'b1},
      '{1'b0, 1'b0, FUNC_MONTH,   1'b1, MONTH_MAX,   1'b1},
      '{1'b1, 1'b0, FUNC_MONTH,   1'b1, FIELD_ONE,   1'b1},
      '{1'b0, 1'b1, FUNC_YEAR,    1'b0, FIELD_ZERO,  1'b0},
      '{1'b0, 1'b1, FUNC_YEAR,    1'b0, FIELD_ZERO,  1'b0},
      '{1'b1, 1'b1, FUNC_YEAR,    1'b0, FIELD_ZERO,  1'b0}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (poll_table[i]) begin
      p.clk_level = poll_table[i].clk_level;
      p.dt_level  = poll_table[i].dt_level;
      p.func      = poll_table[i].func;
      send_poll(p, poll_table[i].typed, {poll_table[i].value, poll_table[i].moved});
    end

    // mostly clean turns of one field, with stray polls mixed in
    while (polls_sent < PollTarget) begin
      sel = field_sel_t'(3'($urandom_range(7)));
      up = 1'($urandom_range(1));
      if ($urandom_range(5) == 0) begin
        steps = $urandom_range(60, 110);
        if ($urandom_range(1) == 1) begin
          sel = FUNC_YEAR;
        end
      end else begin
        steps = $urandom_range(1, 16);
      end
      for (int k = 0; k < steps && polls_sent < PollTarget; k++) begin
        if ($urandom_range(99) < 15) begin
          p.clk_level = 1'($urandom_range(1));
          p.dt_level  = 1'($urandom_range(1));
          p.func      = field_sel_t'(3'($urandom_range(7)));
        end else begin
          p.clk_level = ~last_clock;
          p.dt_level  = up ? ~p.clk_level : p.clk_level;
          p.func      = sel;
        end
        send_poll(p, 1'b0, '0);
      end
    end
    item_ch.valid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
